// ===== hw/rtl/shd_pkg.sv =====
package shd_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 30;
    localparam int ROOT_WIDTH    = FRACTION_BITS + 1;
    localparam int DEN_WIDTH     = FRACTION_BITS + 2;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_COPY   = 2'd1;
    localparam logic [1:0] ST_DZERO  = 2'd2;
    localparam logic [1:0] ST_UNREAL = 2'd3;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] first_e1;
        logic signed [VALUE_WIDTH-1:0] first_e2;
        logic signed [VALUE_WIDTH-1:0] second_e1;
        logic signed [VALUE_WIDTH-1:0] second_e2;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sum_e1;
        logic signed [VALUE_WIDTH-1:0] sum_e2;
        logic [1:0]                    status;
    } out_t;

    typedef struct packed {
        logic                          valid;
        logic                          szero;
        logic                          unreal;
        logic                          dzero;
        logic signed [VALUE_WIDTH-1:0] a1;
        logic signed [VALUE_WIDTH-1:0] a2;
        logic signed [VALUE_WIDTH-1:0] b1;
        logic signed [VALUE_WIDTH-1:0] b2;
        logic signed [VALUE_WIDTH:0]   sum1;
        logic signed [VALUE_WIDTH:0]   sum2;
        logic [ROOT_WIDTH-1:0]         cf;
        logic                          cneg;
        logic [DEN_WIDTH-1:0]          df;
    } carry_t;

    typedef struct packed {
        logic [1:0] nneg;
        logic [1:0] nzero;
        logic [1:0] sat;
    } flag_t;

endpackage

// ===== hw/rtl/shear_distortion_composition.sv =====
// Shear distortion composition.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low, so a new pair of distortions may be issued in
// every cycle. operands carries a = (first_e1, first_e2) and
// b = (second_e1, second_e2) in signed Q2.30.
// Output channel: result holds the composed distortion and a status code for
// exactly one cycle, marked by done. The receiver cannot stall; results leave
// in issue order, one per cycle at full rate.
// The pipe is made of three bit-per-stage units in series: an F+1 stage square
// root, an F+1 stage divider for 1/(1+sqrt(1-s)), and a W-1 stage divider for
// the final quotients, plus eight stages of multiply, add, compare and select.
// Throughput: one transaction per cycle.
// Reset: clears all valid bits and the carried operands; no result is
// presented until a transaction has passed through the pipe. The product,
// root and divider registers are not reset.
module shear_distortion_composition (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  shd_pkg::in_t  operands,
    output logic          busy,
    output logic          done,
    output shd_pkg::out_t result
);

    localparam int W    = shd_pkg::VALUE_WIDTH;
    localparam int F    = shd_pkg::FRACTION_BITS;
    localparam int QB   = shd_pkg::ROOT_WIDTH;
    localparam int DW   = shd_pkg::DEN_WIDTH;
    localparam int UW   = 2 * QB;
    localparam int PW   = 2 * W;
    localparam int NW   = W + F + 2;
    localparam int T_I  = 2 * QB + 1;
    localparam int P_I  = 2 * QB + 2;
    localparam int N_I  = 2 * QB + 3;
    localparam int M_I  = 2 * QB + 4;
    localparam int S_I  = 2 * QB + 5;
    localparam int LAST = S_I + W - 1;

    localparam logic [PW-1:0] ONE2  = PW'(1) << (2 * F);
    localparam logic [W-1:0]  VMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  VMAX  = {1'b0, {(W-1){1'b1}}};

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] aa1_reg, aa2_reg, bb1_reg, bb2_reg;
    logic signed [PW-1:0] ab11_reg, ab22_reg, ab12_reg, ab21_reg;
    logic signed [W-1:0]  a1_reg, a2_reg, b1_reg, b2_reg;

    // carry data
    shd_pkg::carry_t cr_reg  [0:LAST];
    shd_pkg::carry_t cr_next [0:LAST];
    shd_pkg::carry_t st2_next;
    logic [UW-1:0]   u_reg, u_next;

    logic [QB+1:0]   sq_rem_reg  [1:QB];
    logic [QB+1:0]   sq_rem_next [1:QB];
    logic [QB-1:0]   sq_root_reg  [1:QB];
    logic [QB-1:0]   sq_root_next [1:QB];
    logic [UW-1:0]   sq_u_reg  [1:QB];
    logic [UW-1:0]   sq_u_next [1:QB];

    logic [2*F:0]    kd_rem_reg  [1:QB];
    logic [2*F:0]    kd_rem_next [1:QB];
    logic [DW-1:0]   kd_den_reg  [1:QB];
    logic [DW-1:0]   kd_den_next [1:QB];
    logic [QB-1:0]   kd_q_reg  [1:QB];
    logic [QB-1:0]   kd_q_next [1:QB];

    logic [QB-1:0]        t_reg, t_next;
    logic [2*QB-1:0]      tk;
    logic signed [QB:0]   ts;
    logic signed [NW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [NW-1:0] n_reg  [2];
    logic signed [NW-1:0] n_next [2];
    logic [NW-1:0]        mag_reg  [2];
    logic [NW-1:0]        mag_next [2];
    logic [1:0]           mneg_reg, mneg_next, mzero_reg, mzero_next;
    logic [NW-1:0]        smag_reg [2];
    shd_pkg::flag_t       sflg_reg, sflg_next;
    logic [NW-1:0]        sat_lim;

    logic [NW-1:0]   qd_rem_reg  [1:W-1][2];
    logic [NW-1:0]   qd_rem_next [1:W-1][2];
    logic [W-2:0]    qd_q_reg  [1:W-1][2];
    logic [W-2:0]    qd_q_next [1:W-1][2];
    shd_pkg::flag_t  qd_flg_reg  [1:W-1];
    shd_pkg::flag_t  qd_flg_next [1:W-1];

    shd_pkg::out_t   result_reg, result_next;
    logic            done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k <= LAST; k++)
            begin
                cr_reg[k] <= '0;
            end
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= cr_reg[LAST].valid;
            cr_reg   <= cr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aa1_reg  <= operands.first_e1 * operands.first_e1;
        aa2_reg  <= operands.first_e2 * operands.first_e2;
        bb1_reg  <= operands.second_e1 * operands.second_e1;
        bb2_reg  <= operands.second_e2 * operands.second_e2;
        ab11_reg <= operands.first_e1 * operands.second_e1;
        ab22_reg <= operands.first_e2 * operands.second_e2;
        ab12_reg <= operands.first_e1 * operands.second_e2;
        ab21_reg <= operands.first_e2 * operands.second_e1;
        a1_reg   <= operands.first_e1;
        a2_reg   <= operands.first_e2;
        b1_reg   <= operands.second_e1;
        b2_reg   <= operands.second_e2;
        u_reg        <= u_next;
        sq_rem_reg   <= sq_rem_next;
        sq_root_reg  <= sq_root_next;
        sq_u_reg     <= sq_u_next;
        kd_rem_reg   <= kd_rem_next;
        kd_den_reg   <= kd_den_next;
        kd_q_reg     <= kd_q_next;
        t_reg        <= t_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        n_reg        <= n_next;
        mag_reg      <= mag_next;
        mneg_reg     <= mneg_next;
        mzero_reg    <= mzero_next;
        smag_reg     <= mag_reg;
        sflg_reg     <= sflg_next;
        qd_rem_reg   <= qd_rem_next;
        qd_q_reg     <= qd_q_next;
        qd_flg_reg   <= qd_flg_next;
        result_reg   <= result_next;
    end

    // stage 2: sums, special-case flags
    always_comb
    begin
        logic [PW-1:0]        s_sum;
        logic [PW-1:0]        b_sum;
        logic signed [PW:0]   d_val;
        logic signed [PW:0]   c_val;
        logic [PW:0]          c_mag;
        s_sum = $unsigned(aa1_reg) + $unsigned(aa2_reg);
        b_sum = $unsigned(bb1_reg) + $unsigned(bb2_reg);
        d_val = $signed({1'b0, ONE2}) + (PW+1)'(ab11_reg) + (PW+1)'(ab22_reg);
        c_val = (PW+1)'(ab12_reg) - (PW+1)'(ab21_reg);
        c_mag = c_val[PW] ? $unsigned(-c_val) : $unsigned(c_val);
        st2_next.valid  = v1_reg;
        st2_next.szero  = (s_sum == '0);
        st2_next.unreal = (s_sum > ONE2) || (b_sum > ONE2);
        st2_next.dzero  = (d_val == '0);
        st2_next.a1     = a1_reg;
        st2_next.a2     = a2_reg;
        st2_next.b1     = b1_reg;
        st2_next.b2     = b2_reg;
        st2_next.sum1   = (W+1)'(a1_reg) + (W+1)'(b1_reg);
        st2_next.sum2   = (W+1)'(a2_reg) + (W+1)'(b2_reg);
        st2_next.cf     = QB'(c_mag >> F);
        st2_next.cneg   = c_val[PW];
        st2_next.df     = DW'(d_val >>> F);
        u_next          = UW'(ONE2 - s_sum);
    end

    assign cr_next[0] = st2_next;

    for (genvar k = 0; k < LAST; k++)
    begin : g_carry
        assign cr_next[k+1] = cr_reg[k];
    end

    // floor square root of 1 - s, one root bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_sqrt
        localparam int J = QB - 1 - i;
        logic [UW-1:0] u_in;
        logic [QB+1:0] rem_in, rem_sh, trial;
        logic [QB-1:0] root_in;
        logic          take;
        if (i == 0)
        begin : g_first
            assign u_in    = u_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_mid
            assign u_in    = sq_u_reg[i];
            assign rem_in  = sq_rem_reg[i];
            assign root_in = sq_root_reg[i];
        end
        assign rem_sh = {rem_in[QB-1:0], u_in[2*J+1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);
        assign sq_rem_next[i+1]  = take ? rem_sh - trial : rem_sh;
        assign sq_root_next[i+1] = {root_in[QB-2:0], take};
        assign sq_u_next[i+1]    = u_in;
    end

    // k = 2^(2F) / (2^F + q), one quotient bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_kdiv
        localparam int J = F - i;
        logic [2*F:0]   rem_in;
        logic [DW-1:0]  den_in;
        logic [QB-1:0]  q_in;
        logic [2*F+1:0] trial;
        logic           take;
        if (i == 0)
        begin : g_first
            assign rem_in = ONE2[2*F:0];
            assign den_in = DW'(sq_root_reg[QB]) + (DW'(1) << F);
            assign q_in   = '0;
        end
        else
        begin : g_mid
            assign rem_in = kd_rem_reg[i];
            assign den_in = kd_den_reg[i];
            assign q_in   = kd_q_reg[i];
        end
        assign trial = (2*F+2)'(den_in) << J;
        assign take  = ({1'b0, rem_in} >= trial);
        assign kd_rem_next[i+1] = take ? rem_in - trial[2*F:0] : rem_in;
        assign kd_den_next[i+1] = den_in;
        assign kd_q_next[i+1]   = q_in | (QB'(take) << J);
    end

    // t = k * |c| >> F, then numerators
    assign tk      = kd_q_reg[QB] * cr_reg[2*QB].cf;
    assign t_next  = QB'(tk >> F);
    assign ts      = cr_reg[T_I].cneg ? -$signed({1'b0, t_reg}) : $signed({1'b0, t_reg});
    assign p1_next = ts * cr_reg[T_I].a2;
    assign p2_next = ts * cr_reg[T_I].a1;
    assign n_next[0] = (NW'(cr_reg[P_I].sum1) <<< F) + p1_reg;
    assign n_next[1] = (NW'(cr_reg[P_I].sum2) <<< F) - p2_reg;

    for (genvar e = 0; e < 2; e++)
    begin : g_mag
        assign mag_next[e]   = n_reg[e][NW-1] ? $unsigned(-n_reg[e]) : $unsigned(n_reg[e]);
        assign mneg_next[e]  = n_reg[e][NW-1];
        assign mzero_next[e] = (n_reg[e] == '0);
        assign sflg_next.sat[e] = (mag_reg[e] >= sat_lim);
    end

    assign sat_lim         = NW'(cr_reg[M_I].df) << (W - 1);
    assign sflg_next.nneg  = mneg_reg;
    assign sflg_next.nzero = mzero_reg;

    // |n| / df for quotients below 2^(W-1), one bit per stage
    for (genvar i = 0; i < W - 1; i++)
    begin : g_qdiv
        localparam int J = W - 2 - i;
        logic [NW-1:0]  trial;
        shd_pkg::flag_t flg_in;
        assign trial = NW'(cr_reg[S_I + i].df) << J;
        if (i == 0)
        begin : g_first
            assign flg_in = sflg_reg;
        end
        else
        begin : g_mid
            assign flg_in = qd_flg_reg[i];
        end
        assign qd_flg_next[i+1] = flg_in;
        for (genvar e = 0; e < 2; e++)
        begin : g_lane
            logic [NW-1:0] rem_in;
            logic [W-2:0]  q_in;
            logic          take;
            if (i == 0)
            begin : g_first
                assign rem_in = smag_reg[e];
                assign q_in   = '0;
            end
            else
            begin : g_mid
                assign rem_in = qd_rem_reg[i][e];
                assign q_in   = qd_q_reg[i][e];
            end
            assign take = (rem_in >= trial);
            assign qd_rem_next[i+1][e] = take ? rem_in - trial : rem_in;
            assign qd_q_next[i+1][e]   = q_in | ((W-1)'(take) << J);
        end
    end

    // select and saturate
    always_comb
    begin
        logic [W-1:0] val [2];
        for (int e = 0; e < 2; e++)
        begin
            if (qd_flg_reg[W-1].nzero[e])
            begin
                val[e] = '0;
            end
            else if (qd_flg_reg[W-1].sat[e])
            begin
                val[e] = qd_flg_reg[W-1].nneg[e] ? VMIN : VMAX;
            end
            else if (qd_flg_reg[W-1].nneg[e])
            begin
                val[e] = -{1'b0, qd_q_reg[W-1][e]};
            end
            else
            begin
                val[e] = {1'b0, qd_q_reg[W-1][e]};
            end
        end
        if (cr_reg[LAST].szero)
        begin
            result_next.sum_e1 = cr_reg[LAST].b1;
            result_next.sum_e2 = cr_reg[LAST].b2;
            result_next.status = shd_pkg::ST_COPY;
        end
        else if (cr_reg[LAST].unreal)
        begin
            result_next.sum_e1 = '0;
            result_next.sum_e2 = '0;
            result_next.status = shd_pkg::ST_UNREAL;
        end
        else if (cr_reg[LAST].dzero)
        begin
            result_next.sum_e1 = '0;
            result_next.sum_e2 = '0;
            result_next.status = shd_pkg::ST_DZERO;
        end
        else
        begin
            result_next.sum_e1 = $signed(val[0]);
            result_next.sum_e2 = $signed(val[1]);
            result_next.status = shd_pkg::ST_NORMAL;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== test/shear_distortion_composition_test.sv =====
module shear_distortion_composition_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        shd_pkg::in_t  op;
        bit            known;
        shd_pkg::out_t res;
    } row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    shd_pkg::in_t   operands;
    logic           busy;
    logic           done;
    shd_pkg::out_t  result;

    shd_pkg::out_t  pending[$];
    row_t  rows[$];
    int    errors;
    int    idle_cycles;
    int    accepted;
    int    received;
    int    status_seen[4];

    shear_distortion_composition dut (
        .clk(clk), .rst_n(rst_n), .start(start), .operands(operands),
        .busy(busy), .done(done), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [shd_pkg::VALUE_WIDTH-1:0] saturate(wide_t v);
        wide_t lim;
        lim = wide_t'(1) <<< (shd_pkg::VALUE_WIDTH - 1);
        if (v >= lim)
            return shd_pkg::VALUE_WIDTH'(lim - 1);
        if (v < -lim)
            return shd_pkg::VALUE_WIDTH'(-lim);
        return v[shd_pkg::VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [shd_pkg::VALUE_WIDTH-1:0] divide(wide_t n, wide_t df);
        wide_t m, q;
        if (n == 0)
            return '0;
        m = (n < 0) ? -n : n;
        q = (df == 0) ? (wide_t'(1) <<< 126) : m / df;
        return saturate((n < 0) ? -q : q);
    endfunction

    function automatic shd_pkg::out_t compose(shd_pkg::in_t x);
        shd_pkg::out_t r;
        wide_t a1, a2, b1, b2, one2, s, bsq, d, u, q, c, k, cf, t, n1, n2, df;
        a1 = wide_t'(x.first_e1);
        a2 = wide_t'(x.first_e2);
        b1 = wide_t'(x.second_e1);
        b2 = wide_t'(x.second_e2);
        one2 = wide_t'(1) <<< (2 * shd_pkg::FRACTION_BITS);
        s = a1 * a1 + a2 * a2;
        bsq = b1 * b1 + b2 * b2;
        r = '0;
        if (s == 0)
        begin
            r.sum_e1 = x.second_e1;
            r.sum_e2 = x.second_e2;
            r.status = shd_pkg::ST_COPY;
            return r;
        end
        if (s > one2 || bsq > one2)
        begin
            r.status = shd_pkg::ST_UNREAL;
            return r;
        end
        d = one2 + a1 * b1 + a2 * b2;
        if (d == 0)
        begin
            r.status = shd_pkg::ST_DZERO;
            return r;
        end
        u = one2 - s;
        q = 0;
        for (int i = shd_pkg::FRACTION_BITS; i >= 0; i--)
            if ((q | (wide_t'(1) <<< i)) * (q | (wide_t'(1) <<< i)) <= u)
                q = q | (wide_t'(1) <<< i);
        k = one2 / ((wide_t'(1) <<< shd_pkg::FRACTION_BITS) + q);
        c = a1 * b2 - a2 * b1;
        cf = ((c < 0) ? -c : c) >>> shd_pkg::FRACTION_BITS;
        t = (k * cf) >>> shd_pkg::FRACTION_BITS;
        if (c < 0)
            t = -t;
        n1 = ((a1 + b1) <<< shd_pkg::FRACTION_BITS) + t * a2;
        n2 = ((a2 + b2) <<< shd_pkg::FRACTION_BITS) - t * a1;
        df = d >>> shd_pkg::FRACTION_BITS;
        r.sum_e1 = divide(n1, df);
        r.sum_e2 = divide(n2, df);
        r.status = shd_pkg::ST_NORMAL;
        return r;
    endfunction

    function automatic logic signed [shd_pkg::VALUE_WIDTH-1:0] unit_value();
        int unsigned mode;
        mode = $urandom_range(0, 3);
        case (mode)
            0: return $signed(32'($urandom_range(0, 2 ** 29))) * ($urandom_range(0, 1) ? 1 : -1);
            1: return $signed(32'($urandom_range(0, 2 ** 20))) - (2 ** 19);
            2: return $signed(32'($urandom_range(0, 2 ** 29 + 2 ** 28)))
                      * ($urandom_range(0, 1) ? 1 : -1);
            default: return $signed(32'($urandom_range(0, 2 ** 10))) - (2 ** 9);
        endcase
    endfunction

    function automatic shd_pkg::in_t random_item();
        shd_pkg::in_t x;
        int unsigned kind;
        kind = $urandom_range(0, 19);
        x.first_e1 = unit_value();
        x.first_e2 = unit_value();
        x.second_e1 = unit_value();
        x.second_e2 = unit_value();
        if (kind < 2)
        begin
            x.first_e1 = '0;
            x.first_e2 = '0;
            if (kind == 0)
            begin
                x.second_e1 = $urandom;
                x.second_e2 = $urandom;
            end
        end
        else if (kind < 4)
        begin
            x.first_e1 = $urandom;
            x.first_e2 = $urandom;
            x.second_e1 = $urandom;
            x.second_e2 = $urandom;
        end
        else if (kind == 4)
        begin
            x.first_e1 = -x.second_e1;
            x.first_e2 = -x.second_e2;
        end
        return x;
    endfunction

    function automatic row_t make_row(int a1, int a2, int b1, int b2, bit known,
                                      int r1, int r2, logic [1:0] st);
        row_t w;
        w.op = '{first_e1: a1, first_e2: a2, second_e1: b1, second_e2: b2};
        w.known = known;
        w.res = '{sum_e1: r1, sum_e2: r2, status: st};
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending.push_back(compose(operands));
                accepted++;
            end
            if (done)
            begin
                received++;
                status_seen[result.status]++;
                if (pending.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction %h", $time, result);
                end
                else
                begin
                    shd_pkg::out_t want;
                    want = pending.pop_front();
                    if (want.sum_e1 !== result.sum_e1)
                    begin
                        errors++;
                        $display("%0t: sum_e1 expected %h actual %h", $time,
                                 want.sum_e1, result.sum_e1);
                    end
                    if (want.sum_e2 !== result.sum_e2)
                    begin
                        errors++;
                        $display("%0t: sum_e2 expected %h actual %h", $time,
                                 want.sum_e2, result.sum_e2);
                    end
                    if (want.status !== result.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, result.status);
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000)
            begin
                $display("%0t: timeout, %0d transactions outstanding", $time, pending.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        shd_pkg::in_t x;
        int  gap;
        int  total;
        int  one_q;
        errors = 0;
        idle_cycles = 0;
        accepted = 0;
        received = 0;
        one_q = 2 ** 30;
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first zero: second copied through, including extremes
        rows.push_back(make_row(0, 0, 32'h7fffffff, 32'h80000000, 1,
                                32'h7fffffff, 32'h80000000, shd_pkg::ST_COPY));
        rows.push_back(make_row(0, 0, 0, 0, 1, 0, 0, shd_pkg::ST_COPY));
        rows.push_back(make_row(0, 0, 32'h80000000, -1, 1, 32'h80000000, -1,
                                shd_pkg::ST_COPY));
        // not realizable
        rows.push_back(make_row(32'h7fffffff, 32'h7fffffff, 0, 0, 1, 0, 0,
                                shd_pkg::ST_UNREAL));
        rows.push_back(make_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                1, 0, 0, shd_pkg::ST_UNREAL));
        rows.push_back(make_row(one_q / 2, 0, 32'h7fffffff, 0, 1, 0, 0, shd_pkg::ST_UNREAL));
        rows.push_back(make_row(one_q + 1, 0, 0, 0, 1, 0, 0, shd_pkg::ST_UNREAL));
        // denominator zero
        rows.push_back(make_row(one_q, 0, -one_q, 0, 1, 0, 0, shd_pkg::ST_DZERO));
        rows.push_back(make_row(0, -one_q, 0, one_q, 1, 0, 0, shd_pkg::ST_DZERO));
        // unit magnitude, tiny denominator, overflow, ordinary values
        rows.push_back(make_row(one_q, 0, 0, 0, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(one_q, 0, one_q, 0, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(one_q, 0, -one_q + 1, 0, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(one_q, 0, -one_q + 3, 5000, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(0, one_q, 1000, -one_q + 1, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(1, 0, 0, 0, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(0, -1, one_q, 0, 0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(one_q / 2, one_q / 3, -one_q / 4, one_q / 5, 0, 0, 0,
                                shd_pkg::ST_NORMAL));
        rows.push_back(make_row(-one_q / 2, -one_q / 2, one_q / 2, -one_q / 2,
                                0, 0, 0, shd_pkg::ST_NORMAL));
        rows.push_back(make_row(759250125, -759250125, -759250124, 759250124,
                                0, 0, 0, shd_pkg::ST_NORMAL));

        total = rows.size() + 2000;
        for (int i = 0; i < total; i++)
        begin
            if (i < rows.size())
                x = rows[i].op;
            else
                x = random_item();
            if (i < rows.size() && rows[i].known && compose(x) !== rows[i].res)
            begin
                errors++;
                $display("%0t: table row %0d expected %h predicted %h", $time, i,
                         rows[i].res, compose(x));
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ((i / 200) % 3 == 1)
                gap = 0;
            if (i == rows.size() || i == total / 2)
            begin
                start <= 1'b0;
                while (pending.size() != 0)
                    @(posedge clk);
                gap = 0;
            end
            else if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            operands <= x;
            do
                @(posedge clk);
            while (busy);
        end
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Composed %0d shear pairs, %0d results checked", accepted, received);
        $display("Status mix: normal %0d, copy %0d, zero denominator %0d, unrealizable %0d",
                 status_seen[shd_pkg::ST_NORMAL], status_seen[shd_pkg::ST_COPY],
                 status_seen[shd_pkg::ST_DZERO], status_seen[shd_pkg::ST_UNREAL]);
        if (errors == 0 && pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/shd_pkg.sv
hw/rtl/shear_distortion_composition.sv
test/shear_distortion_composition_test.sv
